// ----- rtl/thread_cpu_budget_throttle_defines.svh -----
// ---------------------------------------------------------------------------
// thread cpu budget throttle assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef THREAD_CPU_BUDGET_THROTTLE_DEFINES_SVH
`define THREAD_CPU_BUDGET_THROTTLE_DEFINES_SVH

// same-cycle implication
`define TCBT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcbt check failed");

// next-cycle implication
`define TCBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcbt check failed");

`endif

// ----- rtl/tcbt_pkg.sv -----
// ---------------------------------------------------------------------------
// tcbt_pkg
// types, codes and credit arithmetic of the thread cpu budget throttle
// ---------------------------------------------------------------------------
package tcbt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_SAMPLE,
      ST_ADJUST,
      ST_DONE
   } state_type;

   localparam logic [1:0] FUNC_ENROLL = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_DROP   = 2'd2;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_SUSPEND  = 3'd1;
   localparam logic [2:0] ACT_RESUME   = 3'd2;
   localparam logic [2:0] ACT_ENROLLED = 3'd3;
   localparam logic [2:0] ACT_LISTED   = 3'd4;
   localparam logic [2:0] ACT_SKIPPED  = 3'd5;
   localparam logic [2:0] ACT_DEAD     = 3'd6;

   localparam logic CSR_TIME_LIMIT = 1'b0;
   localparam logic CSR_TIME_SLOT  = 1'b1;

   localparam logic [30:0] RESET_BUDGET = 31'(100000 * 2);

   typedef struct packed {
      logic [31:0]        last_time;
      logic signed [31:0] credit;
      logic               suspended;
      logic               live;
   } rec_type;

   typedef struct packed {
      logic [5:0]         slot;
      logic [2:0]         action;
      logic               suspended;
      logic signed [31:0] credit;
   } rsp_type;

   function automatic logic signed [31:0] sat34(input logic signed [33:0] s);
      logic signed [31:0] r;
      if (s[33:31] != {3{s[33]}}) begin
         r = s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic [31:0] d);
      logic signed [33:0] s;
      s = 34'(a) + $signed({2'b00, d});
      return sat34(s);
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic [30:0] d);
      logic signed [33:0] s;
      s = 34'(a) - $signed({3'b000, d});
      return sat34(s);
   endfunction

endpackage

// ----- rtl/tcbt_table.sv -----
// ---------------------------------------------------------------------------
// tcbt_table
// thread id memory and entry record memory, one read and one write port each
// ---------------------------------------------------------------------------
module tcbt_table #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  logic                                 tid_we,
   input  logic                                 rec_we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [31:0]                          wr_tid,
   input  tcbt_pkg::rec_type                    wr_rec,
   output logic [31:0]                          rd_tid,
   output tcbt_pkg::rec_type                    rd_rec
);

   logic [31:0]       tid_mem [DEPTH];
   tcbt_pkg::rec_type rec_mem [DEPTH];

   logic [31:0]       rd_tid_ff;
   tcbt_pkg::rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (tid_we) begin
         tid_mem[wr_addr] <= wr_tid;
      end
      if (rec_we) begin
         rec_mem[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_tid_ff <= tid_mem[rd_addr];
         rd_rec_ff <= rec_mem[rd_addr];
      end
   end

   assign rd_tid = rd_tid_ff;
   assign rd_rec = rd_rec_ff;

endmodule

// ----- rtl/thread_cpu_budget_throttle.sv -----
// ---------------------------------------------------------------------------
// thread_cpu_budget_throttle
// Keeps a table of up to MAX_ENTRIES threads in two synchronous memories (thread id, and a record
// of last time, credit and flags) and answers one response per request. One request is worked at
// a time. An enroll reads the thread id memory one entry per cycle from entry zero and stops early
// on a match; sample and drop go through the record memory read, the saturating add and the limit
// compare with its second subtract. A new request is taken while the previous response still
// waits on rsp_ready.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module thread_cpu_budget_throttle #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [31:0]        req_thread_id,
   input  logic [5:0]         req_entry_index,
   input  logic [31:0]        req_time_reading,
   input  logic               req_read_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_entry_slot,
   output logic [2:0]         rsp_action,
   output logic               rsp_is_suspended,
   output logic signed [31:0] rsp_credit_now,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;

   tcbt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       cmp_ff, cmp_in;
   logic signed [31:0]  work_credit_ff, work_credit_in;
   tcbt_pkg::rsp_type   res_ff, res_in;
   tcbt_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [30:0]         limit_ff, slot_ff;

   logic [1:0]          func_ff;
   logic [31:0]         tid_ff;
   logic [5:0]          idx_ff;
   logic [31:0]         reading_ff;
   logic                ok_ff;

   logic                rd_en, tid_we, rec_we, rsp_load, req_take;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [31:0]         wr_tid, rd_tid;
   tcbt_pkg::rec_type   wr_rec, rd_rec;

   logic [CMPW-1:0]     req_idx_w, idx_w, count_w, cmp_slot_w, app_slot_w;
   logic [CW-1:0]       cmp_next_w;
   logic                req_in_range, scan_last, count_full, neg;
   logic signed [31:0]  credit_2;

   tcbt_table #(
      .DEPTH(MAX_ENTRIES)
   ) u_tcbt_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .tid_we (tid_we),
      .rec_we (rec_we),
      .wr_addr(wr_addr),
      .wr_tid (wr_tid),
      .wr_rec (wr_rec),
      .rd_tid (rd_tid),
      .rd_rec (rd_rec)
   );

   assign req_idx_w    = CMPW'(req_entry_index);
   assign idx_w        = CMPW'(idx_ff);
   assign count_w      = CMPW'(count_ff);
   assign cmp_slot_w   = CMPW'(cmp_ff);
   assign app_slot_w   = CMPW'(count_ff);
   assign cmp_next_w   = CW'(cmp_ff) + CW'(1);
   assign req_in_range = req_idx_w < count_w;
   assign scan_last    = cmp_next_w == count_ff;
   assign count_full   = count_ff == CW'(MAX_ENTRIES);
   assign neg          = work_credit_ff[31];
   assign credit_2     = tcbt_pkg::sat_sub(work_credit_ff, slot_ff);
   assign req_take     = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cmp_in         = cmp_ff;
      work_credit_in = work_credit_ff;
      res_in         = res_ff;
      rd_en          = 1'b0;
      rd_addr        = cmp_ff;
      tid_we         = 1'b0;
      rec_we         = 1'b0;
      wr_addr        = idx_w[AW-1:0];
      wr_tid         = tid_ff;
      wr_rec         = rd_rec;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;

      unique case (state_ff)
         tcbt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func) inside
                  tcbt_pkg::FUNC_ENROLL: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     cmp_in   = '0;
                     state_in = (count_ff == '0) ? tcbt_pkg::ST_APPEND : tcbt_pkg::ST_SCAN;
                  end
                  tcbt_pkg::FUNC_SAMPLE, tcbt_pkg::FUNC_DROP: begin
                     if (req_in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_idx_w[AW-1:0];
                        state_in = tcbt_pkg::ST_SAMPLE;
                     end else begin
                        res_in   = '{req_entry_index, tcbt_pkg::ACT_DEAD, 1'b0, 32'sd0};
                        state_in = tcbt_pkg::ST_DONE;
                     end
                  end
                  default: begin
                     res_in   = '{6'd0, tcbt_pkg::ACT_NONE, 1'b0, 32'sd0};
                     state_in = tcbt_pkg::ST_DONE;
                  end
               endcase
            end
         end

         tcbt_pkg::ST_SCAN: begin
            if (rd_tid == tid_ff) begin
               res_in   = '{cmp_slot_w[5:0], tcbt_pkg::ACT_LISTED, rd_rec.suspended,
                            rd_rec.credit};
               state_in = tcbt_pkg::ST_DONE;
            end else if (scan_last) begin
               state_in = tcbt_pkg::ST_APPEND;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cmp_ff + AW'(1);
               cmp_in  = cmp_ff + AW'(1);
            end
         end

         tcbt_pkg::ST_APPEND: begin
            if (!ok_ff || count_full) begin
               res_in = '{6'd0, tcbt_pkg::ACT_SKIPPED, 1'b0, 32'sd0};
            end else begin
               tid_we   = 1'b1;
               rec_we   = 1'b1;
               wr_addr  = count_ff[AW-1:0];
               wr_rec   = '{reading_ff, 32'sd0, 1'b0, 1'b1};
               count_in = count_ff + CW'(1);
               res_in   = '{app_slot_w[5:0], tcbt_pkg::ACT_ENROLLED, 1'b0, 32'sd0};
            end
            state_in = tcbt_pkg::ST_DONE;
         end

         tcbt_pkg::ST_SAMPLE: begin
            if (!rd_rec.live || func_ff == tcbt_pkg::FUNC_DROP || !ok_ff) begin
               rec_we      = rd_rec.live;
               wr_rec.live = 1'b0;
               res_in      = '{idx_ff, tcbt_pkg::ACT_DEAD, rd_rec.suspended, rd_rec.credit};
               state_in    = tcbt_pkg::ST_DONE;
            end else if (rd_rec.suspended) begin
               work_credit_in = tcbt_pkg::sat_sub(rd_rec.credit, slot_ff);
               state_in       = tcbt_pkg::ST_ADJUST;
            end else begin
               work_credit_in = tcbt_pkg::sat_add(rd_rec.credit, reading_ff - rd_rec.last_time);
               state_in       = tcbt_pkg::ST_ADJUST;
            end
         end

         tcbt_pkg::ST_ADJUST: begin
            rec_we = 1'b1;
            if (rd_rec.suspended) begin
               wr_rec = '{rd_rec.last_time, work_credit_ff, !neg, 1'b1};
               res_in = '{idx_ff, neg ? tcbt_pkg::ACT_RESUME : tcbt_pkg::ACT_NONE, !neg,
                          work_credit_ff};
            end else if (work_credit_ff > $signed({1'b0, limit_ff})) begin
               wr_rec = '{reading_ff, credit_2, 1'b1, 1'b1};
               res_in = '{idx_ff, tcbt_pkg::ACT_SUSPEND, 1'b1, credit_2};
            end else begin
               wr_rec = '{reading_ff, work_credit_ff, 1'b0, 1'b1};
               res_in = '{idx_ff, tcbt_pkg::ACT_NONE, 1'b0, work_credit_ff};
            end
            state_in = tcbt_pkg::ST_DONE;
         end

         tcbt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = tcbt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcbt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcbt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= tcbt_pkg::RESET_BUDGET;
         slot_ff      <= tcbt_pkg::RESET_BUDGET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tcbt_pkg::CSR_TIME_LIMIT: limit_ff <= csr_wdata;
               tcbt_pkg::CSR_TIME_SLOT:  slot_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff         <= cmp_in;
      work_credit_ff <= work_credit_in;
      res_ff         <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
      if (req_take) begin
         func_ff    <= req_func;
         tid_ff     <= req_thread_id;
         idx_ff     <= req_entry_index;
         reading_ff <= req_time_reading;
         ok_ff      <= req_read_ok;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_slot   = rsp_ff.slot;
   assign rsp_action       = rsp_ff.action;
   assign rsp_is_suspended = rsp_ff.suspended;
   assign rsp_credit_now   = rsp_ff.credit;

endmodule

// ----- rtl/tcbt_checker.sv -----
// ---------------------------------------------------------------------------
// tcbt_checker
// port level checks of the thread cpu budget throttle, bound to the top level
// ---------------------------------------------------------------------------
`include "thread_cpu_budget_throttle_defines.svh"

module tcbt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [5:0]         rsp_entry_slot,
   input logic [2:0]         rsp_action,
   input logic               rsp_is_suspended,
   input logic signed [31:0] rsp_credit_now
);

   logic [41:0] rsp_word;
   logic        rsp_stall, is_skip, skip_zero, is_resume, resume_neg, is_flagged, flag_want;

   assign rsp_word   = {rsp_entry_slot, rsp_action, rsp_is_suspended, rsp_credit_now};
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign is_skip    = rsp_valid && rsp_action == tcbt_pkg::ACT_SKIPPED;
   assign skip_zero  = rsp_entry_slot == 6'd0 && !rsp_is_suspended && rsp_credit_now == 32'sd0;
   assign is_resume  = rsp_valid && rsp_action == tcbt_pkg::ACT_RESUME;
   assign resume_neg = !rsp_is_suspended && rsp_credit_now[31];
   assign is_flagged = rsp_valid && (rsp_action == tcbt_pkg::ACT_SUSPEND ||
                                     rsp_action == tcbt_pkg::ACT_ENROLLED);
   assign flag_want  = rsp_action == tcbt_pkg::ACT_SUSPEND;

   // stalled response holds
   `TCBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // skipped enroll reports all zero
   `TCBT_ASSERT_IMPLY(a_skip_zero, clock, reset, is_skip, skip_zero)

   // resume only with negative credit
   `TCBT_ASSERT_IMPLY(a_resume_neg, clock, reset, is_resume, resume_neg)

   // suspend and fresh enroll flags
   `TCBT_ASSERT_IMPLY(a_flag_match, clock, reset, is_flagged, rsp_is_suspended == flag_want)

endmodule

bind thread_cpu_budget_throttle tcbt_checker u_tcbt_checker (.*);

// ----- verif/thread_cpu_budget_throttle_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thread_cpu_budget_throttle_tb
// Drives enroll, sample and drop requests into the thread budget throttle and checks
// every response against a cycle-free model of the thread table, or against the fixed answer
// of a typed directed row. A short table of directed requests covers reset state, field extremes
// and the dead, skipped and listed answers; random phases follow, each under its own time_limit
// and time_slot setting, with random idling on both channels.
// ---------------------------------------------------------------------------
module thread_cpu_budget_throttle_tb;

   localparam int TBL_DEPTH = 64;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 106;
   localparam int DRAIN_CYCLES = 200;
   localparam int LIMIT_NS = 4_000_000;
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam logic [30:0] BUDGET_MAX = 31'h7FFF_FFFF;
   localparam longint CREDIT_MAX = 64'sd2147483647;
   localparam longint CREDIT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] tid;
      logic [5:0]  idx;
      logic [31:0] reading;
      logic        ok;
   } req_type;

   typedef struct packed {
      req_type           req;
      logic              typed;
      tcbt_pkg::rsp_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TBL [20] = '{
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd0, 32'h0, 1'b1}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_DEAD, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_DROP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{6'd63, tcbt_pkg::ACT_DEAD, 1'b0, 32'sd0}},
      '{'{FUNC_SPARE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_NONE, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'hFFFF_FFFF, 6'd0, 32'h0, 1'b0}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_SKIPPED, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFF0, 1'b1}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_ENROLLED, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'hFFFF_FFFF, 6'd0, 32'h0, 1'b0}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_LISTED, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'h0, 6'd0, 32'h0, 1'b1}, 1'b1,
        '{6'd1, tcbt_pkg::ACT_ENROLLED, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd0, 32'h0000_0010, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd0, 32'h0004_93F0, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd0, 32'h0004_93F0, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd1, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd1, 32'h0, 1'b0}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd1, 32'h0, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_DROP, 32'h0, 6'd0, 32'h0, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'h0, 6'd0, 32'h0, 1'b1}, 1'b0, '0},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd2, 32'h0, 1'b1}, 1'b1,
        '{6'd2, tcbt_pkg::ACT_DEAD, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_ENROLL, 32'h5A5A_5A5A, 6'd0, 32'h1234_5678, 1'b1}, 1'b1,
        '{6'd2, tcbt_pkg::ACT_ENROLLED, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_SAMPLE, 32'h0, 6'd2, 32'h1234_5678, 1'b1}, 1'b1,
        '{6'd2, tcbt_pkg::ACT_NONE, 1'b0, 32'sd0}},
      '{'{tcbt_pkg::FUNC_DROP, 32'h0, 6'd2, 32'h0, 1'b0}, 1'b0, '0},
      '{'{FUNC_SPARE, 32'h0, 6'd0, 32'h0, 1'b0}, 1'b1,
        '{6'd0, tcbt_pkg::ACT_NONE, 1'b0, 32'sd0}}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_func;
   logic [31:0] req_thread_id;
   logic [5:0] req_entry_index;
   logic [31:0] req_time_reading;
   logic req_read_ok;
   logic rsp_valid;
   logic rsp_ready;
   logic [5:0] rsp_entry_slot;
   logic [2:0] rsp_action;
   logic rsp_is_suspended;
   logic signed [31:0] rsp_credit_now;
   logic csr_valid;
   logic csr_ready;
   logic csr_index;
   logic [30:0] csr_wdata;

   // thread table model
   logic [31:0] tbl_tid [TBL_DEPTH];
   logic [31:0] tbl_last [TBL_DEPTH];
   logic signed [31:0] tbl_credit [TBL_DEPTH];
   logic tbl_susp [TBL_DEPTH];
   logic tbl_live [TBL_DEPTH];
   int tbl_count = 0;
   logic [30:0] lim_q = tcbt_pkg::RESET_BUDGET;
   logic [30:0] slot_q = tcbt_pkg::RESET_BUDGET;

   tcbt_pkg::rsp_type verdict_q [$];
   int err_count = 0;
   int rsp_count = 0;
   bit sender_calm = 1'b0;

   always #2 clock = ~clock;

   thread_cpu_budget_throttle #(
      .MAX_ENTRIES(TBL_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_thread_id(req_thread_id),
      .req_entry_index(req_entry_index),
      .req_time_reading(req_time_reading),
      .req_read_ok(req_read_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_entry_slot(rsp_entry_slot),
      .rsp_action(rsp_action),
      .rsp_is_suspended(rsp_is_suspended),
      .rsp_credit_now(rsp_credit_now),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic logic signed [31:0] clamp_credit(input longint v);
      if (v > CREDIT_MAX) return 32'sh7FFF_FFFF;
      if (v < CREDIT_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic void apply_throttle(input req_type r, output tcbt_pkg::rsp_type o);
      int hit;
      logic [31:0] diff;
      o = '0;
      hit = -1;
      case (r.func) inside
         tcbt_pkg::FUNC_ENROLL: begin
            for (int j = 0; j < tbl_count; j++) begin
               if (hit < 0 && tbl_tid[j] == r.tid) hit = j;
            end
            if (hit >= 0) begin
               o.slot = 6'(hit);
               o.action = tcbt_pkg::ACT_LISTED;
               o.suspended = tbl_susp[hit];
               o.credit = tbl_credit[hit];
            end else if (!r.ok || tbl_count >= TBL_DEPTH) begin
               o.action = tcbt_pkg::ACT_SKIPPED;
            end else begin
               tbl_tid[tbl_count] = r.tid;
               tbl_last[tbl_count] = r.reading;
               tbl_credit[tbl_count] = '0;
               tbl_susp[tbl_count] = 1'b0;
               tbl_live[tbl_count] = 1'b1;
               o.slot = 6'(tbl_count);
               o.action = tcbt_pkg::ACT_ENROLLED;
               tbl_count++;
            end
         end
         tcbt_pkg::FUNC_SAMPLE, tcbt_pkg::FUNC_DROP: begin
            o.slot = r.idx;
            if (int'(r.idx) >= tbl_count) begin
               o.action = tcbt_pkg::ACT_DEAD;
            end else if (!tbl_live[r.idx] || r.func == tcbt_pkg::FUNC_DROP || !r.ok) begin
               tbl_live[r.idx] = 1'b0;
               o.action = tcbt_pkg::ACT_DEAD;
               o.suspended = tbl_susp[r.idx];
               o.credit = tbl_credit[r.idx];
            end else if (tbl_susp[r.idx]) begin
               tbl_credit[r.idx] = clamp_credit(longint'(tbl_credit[r.idx]) - longint'(slot_q));
               o.action = tcbt_pkg::ACT_NONE;
               if (tbl_credit[r.idx] < 0) begin
                  tbl_susp[r.idx] = 1'b0;
                  o.action = tcbt_pkg::ACT_RESUME;
               end
               o.suspended = tbl_susp[r.idx];
               o.credit = tbl_credit[r.idx];
            end else begin
               diff = r.reading - tbl_last[r.idx];
               tbl_credit[r.idx] = clamp_credit(longint'(tbl_credit[r.idx]) + longint'(diff));
               tbl_last[r.idx] = r.reading;
               o.action = tcbt_pkg::ACT_NONE;
               if (longint'(tbl_credit[r.idx]) > longint'(lim_q)) begin
                  tbl_susp[r.idx] = 1'b1;
                  tbl_credit[r.idx] =
                     clamp_credit(longint'(tbl_credit[r.idx]) - longint'(slot_q));
                  o.action = tcbt_pkg::ACT_SUSPEND;
               end
               o.suspended = tbl_susp[r.idx];
               o.credit = tbl_credit[r.idx];
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want_v);
      err_count++;
      if (err_count <= 40)
         $display("%0t mismatch on %s: got %0d, expected %0d, response %0d",
                  $time, what, got, want_v, rsp_count);
   endtask

   // valid stays high across back-to-back requests
   task automatic send_request(input req_type it, input logic typed,
                               input tcbt_pkg::rsp_type want);
      int gap;
      int r;
      tcbt_pkg::rsp_type pred;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 45) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_thread_id <= it.tid;
      req_entry_index <= it.idx;
      req_time_reading <= it.reading;
      req_read_ok <= it.ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_throttle(it, pred);
      verdict_q.push_back(typed ? want : pred);
   endtask

   always @(posedge clock) begin
      tcbt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("response with none pending", longint'(rsp_action), 0);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_entry_slot !== want.slot)
               report_mismatch("entry_slot", longint'(rsp_entry_slot), longint'(want.slot));
            if (rsp_action !== want.action)
               report_mismatch("action", longint'(rsp_action), longint'(want.action));
            if (rsp_is_suspended !== want.suspended)
               report_mismatch("is_suspended", longint'(rsp_is_suspended),
                               longint'(want.suspended));
            if (rsp_credit_now !== want.credit)
               report_mismatch("credit_now", longint'(rsp_credit_now), longint'(want.credit));
            rsp_count++;
         end
      end
   end

   // response back-pressure
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 15) n = $urandom_range(50, 200);
         else n = $urandom_range(1, 8);
         repeat (n) @(posedge clock);
         if ($urandom_range(0, 99) < 60) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 99) < 95) n = $urandom_range(1, 4);
            else n = $urandom_range(20, 60);
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      req_type item;
      int pct;
      int r;
      int j;
      int tries;
      logic [30:0] lim;
      logic [30:0] slt;
      logic [31:0] delta;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= tcbt_pkg::FUNC_ENROLL;
      req_thread_id <= '0;
      req_entry_index <= '0;
      req_time_reading <= '0;
      req_read_ok <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= tcbt_pkg::CSR_TIME_LIMIT;
      csr_wdata <= '0;
      for (int k = 0; k < TBL_DEPTH; k++) begin
         tbl_tid[k] = '0;
         tbl_last[k] = '0;
         tbl_credit[k] = '0;
         tbl_susp[k] = 1'b0;
         tbl_live[k] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TBL[k]) send_request(DIR_TBL[k].req, DIR_TBL[k].typed, DIR_TBL[k].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         while (verdict_q.size() != 0) @(posedge clock);
         case (ph)
            0: begin lim = tcbt_pkg::RESET_BUDGET; slt = 31'd50000; end
            1: begin lim = '0; slt = BUDGET_MAX; end
            2: begin lim = BUDGET_MAX; slt = '0; end
            3: begin lim = '0; slt = '0; end
            4: begin lim = BUDGET_MAX; slt = BUDGET_MAX; end
            5: begin
               lim = 31'($urandom_range(1, 1000000));
               slt = 31'($urandom_range(1, lim));
            end
            6: begin lim = 31'd1000; slt = 31'd300; end
            default: begin lim = 31'($urandom); slt = 31'($urandom); end
         endcase
         csr_valid <= 1'b1;
         csr_index <= tcbt_pkg::CSR_TIME_LIMIT;
         csr_wdata <= lim;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         lim_q = lim;
         csr_index <= tcbt_pkg::CSR_TIME_SLOT;
         csr_wdata <= slt;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         slot_q = slt;
         csr_valid <= 1'b0;
         sender_calm = (ph % 3 == 2);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pct = (tbl_count < 8) ? 40 : 12;
            r = $urandom_range(0, 99);
            item.tid = $urandom;
            item.idx = 6'($urandom_range(0, 63));
            item.reading = $urandom;
            item.ok = ($urandom_range(0, 39) != 0);
            if (r < pct) begin
               item.func = tcbt_pkg::FUNC_ENROLL;
               item.ok = ($urandom_range(0, 9) != 0);
               if (tbl_count > 0 && $urandom_range(0, 5) == 0)
                  item.tid = tbl_tid[$urandom_range(0, tbl_count - 1)];
            end else if (r < pct + 2) begin
               item.func = FUNC_SPARE;
            end else begin
               item.func = (r < pct + 4) ? tcbt_pkg::FUNC_DROP : tcbt_pkg::FUNC_SAMPLE;
               if (tbl_count > 0 && $urandom_range(0, 9) != 0) begin
                  // prefer live entries so the budget logic stays busy
                  j = $urandom_range(0, tbl_count - 1);
                  tries = 0;
                  while (!tbl_live[j] && tries < 8) begin
                     j = $urandom_range(0, tbl_count - 1);
                     tries++;
                  end
                  item.idx = 6'(j);
                  r = $urandom_range(0, 39);
                  if (r < 20) delta = $urandom_range(0, 60000);
                  else if (r < 30) delta = $urandom_range(0, 400000);
                  else if (r < 34) delta = '0;
                  else if (r == 34) delta = $urandom;
                  else if (r == 35) delta = -32'($urandom_range(1, 1000));
                  else delta = $urandom_range(0, 2000);
                  item.reading = tbl_last[j] + delta;
               end
            end
            send_request(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
